// File: rtl/mvna_pkg.sv
// Shared types, constants and saturation helper for the mesh vertex normal accumulator.
// No dependencies; used by every module under rtl/.
package mvna_pkg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_VERTEX = 2'd1,
        MODE_TRI    = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_STEP_X   = 3'd3,
        CFG_STEP_Z   = 3'd4,
        CFG_SCALE_Y  = 3'd5,
        CFG_INV_COLS = 3'd6,
        CFG_INV_ROWS = 3'd7
    } cfg_idx_t;

    localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
    localparam logic [16:0]        TEX_MAX  = 17'd65536;
    localparam logic [61:0]        EPS_SQ   = 62'd18446744;
    localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } pos_entry_t;

    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
    } acc_entry_t;

    typedef struct packed {
        logic               done;
        logic               small_len;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } norm_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = INT32_MAX;
        else if (v < -66'sd2147483648)
            r = INT32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/mvna_store.sv
// Vertex storage: position/texture memory and normal accumulator memory.
// One write and one registered read port each. Depends on mvna_pkg.
module mvna_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                clk,
    input  logic                pos_we,
    input  logic [AW-1:0]       pos_waddr,
    input  mvna_pkg::pos_entry_t pos_wdata,
    input  logic [AW-1:0]       pos_raddr,
    output mvna_pkg::pos_entry_t pos_rdata,
    input  logic                acc_we,
    input  logic [AW-1:0]       acc_waddr,
    input  mvna_pkg::acc_entry_t acc_wdata,
    input  logic [AW-1:0]       acc_raddr,
    output mvna_pkg::acc_entry_t acc_rdata
);
    import mvna_pkg::*;

    pos_entry_t pos_mem [DEPTH];
    acc_entry_t acc_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rdata <= acc_mem[acc_raddr];
    end

endmodule

// File: rtl/mvna_norm.sv
// Iterative vector normalizer: range shift, sum of squares, bit-serial square
// root and three restoring divisions to Q1.14. Depends on mvna_pkg.
module mvna_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  c0,
    input  logic signed [63:0]  c1,
    input  logic signed [63:0]  c2,
    output mvna_pkg::norm_res_t res
);
    import mvna_pkg::*;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_LEN, N_DIVINIT, N_DIV
    } nstate_t;

    nstate_t      st_reg;
    logic [63:0]  m_reg [3];
    logic [2:0]   neg_reg;
    logic         shifted_reg;
    logic [4:0]   cnt_reg;
    logic [59:0]  sqp_reg;
    logic [61:0]  sq_reg;
    logic [63:0]  v_reg;
    logic [63:0]  r_reg;
    logic [31:0]  len_reg;
    logic [45:0]  rem_reg;
    logic [14:0]  q_reg;
    logic [1:0]   j_reg;
    logic signed [15:0] n_reg [3];
    logic         done_reg;
    logic         small_reg;

    logic [63:0]  mx;
    logic [29:0]  sq_op;
    logic [59:0]  sqp_next;
    logic [61:0]  sq_final;
    logic [63:0]  bit_val;
    logic [63:0]  trial;
    logic [45:0]  div_t;
    logic [14:0]  q_next;
    logic [63:0]  m_sel;

    assign mx = m_reg[0] | m_reg[1] | m_reg[2];

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    sq_op = m_reg[0][29:0];
            2'd1:    sq_op = m_reg[1][29:0];
            default: sq_op = m_reg[2][29:0];
        endcase
    end

    always_comb
    begin
        unique case (j_reg)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            default: m_sel = m_reg[2];
        endcase
    end

    assign sqp_next = 60'(sq_op) * 60'(sq_op);
    assign sq_final = sq_reg + 62'(sqp_reg);
    assign bit_val  = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
    assign trial    = r_reg + bit_val;
    assign div_t    = 46'(len_reg) << cnt_reg[3:0];

    always_comb
    begin
        q_next = q_reg;
        if (rem_reg >= div_t)
        begin
            q_next[cnt_reg[3:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= N_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            sqp_reg  <= sqp_next;
            unique case (st_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        m_reg[0]    <= c0[63] ? 64'(-c0) : 64'(c0);
                        m_reg[1]    <= c1[63] ? 64'(-c1) : 64'(c1);
                        m_reg[2]    <= c2[63] ? 64'(-c2) : 64'(c2);
                        neg_reg     <= {c2[63], c1[63], c0[63]};
                        shifted_reg <= 1'b0;
                        st_reg      <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // coarse step while far above range, then single bits
                    if (mx[63:34] != '0)
                    begin
                        m_reg[0]    <= m_reg[0] >> 4;
                        m_reg[1]    <= m_reg[1] >> 4;
                        m_reg[2]    <= m_reg[2] >> 4;
                        shifted_reg <= 1'b1;
                    end
                    else if (mx[63:30] != '0)
                    begin
                        m_reg[0]    <= m_reg[0] >> 1;
                        m_reg[1]    <= m_reg[1] >> 1;
                        m_reg[2]    <= m_reg[2] >> 1;
                        shifted_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        sq_reg  <= '0;
                        st_reg  <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (cnt_reg != 5'd0)
                    begin
                        sq_reg <= sq_final;
                    end
                    if (cnt_reg == 5'd3)
                    begin
                        v_reg     <= 64'(sq_final);
                        r_reg     <= '0;
                        small_reg <= !shifted_reg && (sq_final <= EPS_SQ);
                        cnt_reg   <= '0;
                        st_reg    <= N_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    if (v_reg >= trial)
                    begin
                        v_reg <= v_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_val;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        st_reg <= N_LEN;
                    end
                end
                N_LEN:
                begin
                    len_reg <= (r_reg == '0) ? 32'd1 : r_reg[31:0];
                    j_reg   <= '0;
                    st_reg  <= N_DIVINIT;
                end
                N_DIVINIT:
                begin
                    rem_reg <= 46'({m_sel[29:0], 14'b0}) + 46'(len_reg >> 1);
                    q_reg   <= '0;
                    cnt_reg <= 5'd14;
                    st_reg  <= N_DIV;
                end
                N_DIV:
                begin
                    if (rem_reg >= div_t)
                    begin
                        rem_reg <= rem_reg - div_t;
                    end
                    q_reg <= q_next;
                    if (cnt_reg == 5'd0)
                    begin
                        n_reg[j_reg] <= neg_reg[j_reg] ? -$signed({1'b0, q_next})
                                                       : $signed({1'b0, q_next});
                        if (j_reg == 2'd2)
                        begin
                            done_reg <= 1'b1;
                            st_reg   <= N_IDLE;
                        end
                        else
                        begin
                            j_reg  <= j_reg + 2'd1;
                            st_reg <= N_DIVINIT;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default:
                begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign res.done      = done_reg;
    assign res.small_len = small_reg;
    assign res.nx        = n_reg[0];
    assign res.ny        = n_reg[1];
    assign res.nz        = n_reg[2];

endmodule

// File: rtl/mesh_vertex_normal_accumulator.sv
// Top level: item sequencer, shared 33x33 multiplier, config registers.
// Uses mvna_pkg, mvna_store (vertex memories) and mvna_norm (normalizer).
//
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+----------------------
//  in      | in_valid in_ready mode ... corner_c      | in_valid & in_ready
//  out     | out_valid out_ready pos_x ... min_height | out_valid & out_ready
//  cfg     | cfg_we cfg_index cfg_data                | cfg_we
//
// One item at a time. Vertex load: five products through the shared multiplier.
// Triangle: the normalizer (range shift, 32-step square root, three divisions) plus
// three accumulator read-modify-writes; a face too small to count skips the
// read-modify-writes. Read: a zero accumulator skips the normalizer.
// Reset needs no memory clearing pass. A finished result waits in the output
// register while the next item is accepted; only the next read stalls on it.
module mesh_vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [11:0]        vertex_index,
    input  logic [11:0]        grid_col,
    input  logic [11:0]        grid_row,
    input  logic signed [31:0] raw_height,
    input  logic [11:0]        corner_a,
    input  logic [11:0]        corner_b,
    input  logic [11:0]        corner_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic signed [31:0] min_height,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import mvna_pkg::*;

    localparam int DEPTH = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] LIMIT = 32'(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE, S_VTX_MUL, S_VTX_WR, S_TRI_RD, S_TRI_MUL, S_TRI_NORM,
        S_ACC_RD, S_ACC_WR, S_RD_ADDR, S_RD_CHK, S_RD_NORM, S_RD_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] cnt_reg;
    logic [1:0] j_reg;

    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [31:0] step_x_reg, step_z_reg, scale_y_reg;
    logic [16:0]        inv_cols_reg, inv_rows_reg;
    logic signed [31:0] run_min_reg;

    logic [11:0]        idx_reg, col_reg, row_reg, a_reg, b_reg, c_reg;
    logic signed [31:0] raw_reg;

    logic signed [63:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [16:0]        tu_reg, tv_reg;
    logic signed [31:0] pa_x_reg, pa_y_reg, pa_z_reg;
    logic signed [31:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [63:0] pe_reg;
    logic signed [63:0] cr_reg [3];
    logic               norm_start_reg;
    logic               up_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_px_reg, out_py_reg, out_pz_reg, out_min_reg;
    logic signed [15:0] out_nx_reg, out_ny_reg, out_nz_reg;
    logic [16:0]        out_tu_reg, out_tv_reg;

    logic               pos_we, acc_we;
    logic [AW-1:0]      pos_raddr, acc_raddr, acc_waddr;
    pos_entry_t         pos_wdata, pos_rdata;
    acc_entry_t         acc_wdata, acc_rdata;
    norm_res_t          norm_res;

    logic [11:0]        corner_sel;
    logic signed [63:0] y_round;
    logic               accept;

    function automatic logic in_range(input logic [11:0] i);
        return {20'b0, i} < LIMIT;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_VTX_MUL)
        begin
            unique case (cnt_reg)
                3'd0:    begin mul_a = 33'({1'b0, col_reg}); mul_b = 33'(step_x_reg); end
                3'd1:    begin mul_a = 33'({1'b0, row_reg}); mul_b = 33'(step_z_reg); end
                3'd2:    begin mul_a = 33'(raw_reg);         mul_b = 33'(scale_y_reg); end
                3'd3:    begin mul_a = 33'({1'b0, col_reg}); mul_b = 33'({1'b0, inv_cols_reg}); end
                3'd4:    begin mul_a = 33'({1'b0, row_reg}); mul_b = 33'({1'b0, inv_rows_reg}); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_TRI_MUL)
        begin
            unique case (cnt_reg)
                3'd0:    begin mul_a = 33'(e1y_reg); mul_b = 33'(e2z_reg); end
                3'd1:    begin mul_a = 33'(e1z_reg); mul_b = 33'(e2y_reg); end
                3'd2:    begin mul_a = 33'(e1z_reg); mul_b = 33'(e2x_reg); end
                3'd3:    begin mul_a = 33'(e1x_reg); mul_b = 33'(e2z_reg); end
                3'd4:    begin mul_a = 33'(e1x_reg); mul_b = 33'(e2y_reg); end
                3'd5:    begin mul_a = 33'(e1y_reg); mul_b = 33'(e2x_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod_next = 66'(mul_a) * 66'(mul_b);
    assign y_round   = (prod_reg + 64'sd32768) >>> 16;

    always_comb
    begin
        unique case (j_reg)
            2'd0:    corner_sel = a_reg;
            2'd1:    corner_sel = b_reg;
            default: corner_sel = c_reg;
        endcase
    end

    // memory port control
    always_comb
    begin
        pos_raddr = idx_reg[AW-1:0];
        if (state_reg == S_TRI_RD)
        begin
            unique case (cnt_reg)
                3'd0:    pos_raddr = a_reg[AW-1:0];
                3'd1:    pos_raddr = b_reg[AW-1:0];
                default: pos_raddr = c_reg[AW-1:0];
            endcase
        end
        acc_raddr = (state_reg == S_ACC_RD) ? corner_sel[AW-1:0] : idx_reg[AW-1:0];
        pos_we    = (state_reg == S_VTX_WR);
        pos_wdata = '{pos_x: px_reg, pos_y: py_reg, pos_z: pz_reg,
                      tex_u: tu_reg, tex_v: tv_reg};
        acc_we    = (state_reg == S_VTX_WR) || (state_reg == S_ACC_WR);
        acc_waddr = (state_reg == S_ACC_WR) ? corner_sel[AW-1:0] : idx_reg[AW-1:0];
        if (state_reg == S_ACC_WR)
        begin
            acc_wdata.acc_x = sat32(66'(acc_rdata.acc_x) + 66'(norm_res.nx));
            acc_wdata.acc_y = sat32(66'(acc_rdata.acc_y) + 66'(norm_res.ny));
            acc_wdata.acc_z = sat32(66'(acc_rdata.acc_z) + 66'(norm_res.nz));
        end
        else
        begin
            acc_wdata.acc_x = '0;
            acc_wdata.acc_y = 32'(ONE_Q14);
            acc_wdata.acc_z = '0;
        end
    end

    mvna_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .pos_we    (pos_we),
        .pos_waddr (idx_reg[AW-1:0]),
        .pos_wdata (pos_wdata),
        .pos_raddr (pos_raddr),
        .pos_rdata (pos_rdata),
        .acc_we    (acc_we),
        .acc_waddr (acc_waddr),
        .acc_wdata (acc_wdata),
        .acc_raddr (acc_raddr),
        .acc_rdata (acc_rdata)
    );

    mvna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start_reg),
        .c0    (cr_reg[0]),
        .c1    (cr_reg[1]),
        .c2    (cr_reg[2]),
        .res   (norm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            j_reg          <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            step_x_reg     <= 32'sd65536;
            step_z_reg     <= 32'sd65536;
            scale_y_reg    <= 32'sd65536;
            inv_cols_reg   <= TEX_MAX;
            inv_rows_reg   <= TEX_MAX;
            run_min_reg    <= INT32_MAX;
            norm_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_reg       <= prod_next[63:0];
            norm_start_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    CFG_STEP_X:   step_x_reg   <= cfg_data;
                    CFG_STEP_Z:   step_z_reg   <= cfg_data;
                    CFG_SCALE_Y:  scale_y_reg  <= cfg_data;
                    CFG_INV_COLS: inv_cols_reg <= cfg_data[16:0];
                    CFG_INV_ROWS: inv_rows_reg <= cfg_data[16:0];
                    default:      inv_rows_reg <= inv_rows_reg;
                endcase
            end

            // a new result in S_RD_OUT takes the register over in the same cycle
            if (out_valid_reg && out_ready && (state_reg != S_RD_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= vertex_index;
                        col_reg <= grid_col;
                        row_reg <= grid_row;
                        raw_reg <= raw_height;
                        a_reg   <= corner_a;
                        b_reg   <= corner_b;
                        c_reg   <= corner_c;
                        cnt_reg <= '0;
                        j_reg   <= '0;
                        unique case (mode_t'(mode))
                            MODE_START:
                            begin
                                run_min_reg <= INT32_MAX;
                            end
                            MODE_VERTEX:
                            begin
                                if (in_range(vertex_index))
                                begin
                                    if (raw_height < run_min_reg)
                                    begin
                                        run_min_reg <= raw_height;
                                    end
                                    state_reg <= S_VTX_MUL;
                                end
                            end
                            MODE_TRI:
                            begin
                                if (in_range(corner_a) && in_range(corner_b) &&
                                    in_range(corner_c))
                                begin
                                    state_reg <= S_TRI_RD;
                                end
                            end
                            default:
                            begin
                                if (in_range(vertex_index))
                                begin
                                    state_reg <= S_RD_ADDR;
                                end
                            end
                        endcase
                    end
                end
                S_VTX_MUL:
                begin
                    // product of step k lands in prod_reg and is used in the cycle after
                    unique case (cnt_reg)
                        3'd1: px_reg <= sat32(66'(origin_x_reg) + 66'(prod_reg));
                        3'd2: pz_reg <= sat32(66'(origin_z_reg) + 66'(prod_reg));
                        3'd3: py_reg <= sat32(66'(origin_y_reg) + 66'(y_round));
                        3'd4: tu_reg <= (prod_reg > 64'sd65536) ? TEX_MAX : prod_reg[16:0];
                        3'd5: tv_reg <= (prod_reg > 64'sd65536) ? TEX_MAX : prod_reg[16:0];
                        default: tv_reg <= tv_reg;
                    endcase
                    if (cnt_reg == 3'd5)
                    begin
                        state_reg <= S_VTX_WR;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_VTX_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_TRI_RD:
                begin
                    unique case (cnt_reg)
                        3'd1:
                        begin
                            pa_x_reg <= pos_rdata.pos_x;
                            pa_y_reg <= pos_rdata.pos_y;
                            pa_z_reg <= pos_rdata.pos_z;
                        end
                        3'd2:
                        begin
                            e1x_reg <= sat32(66'(pos_rdata.pos_x) - 66'(pa_x_reg));
                            e1y_reg <= sat32(66'(pos_rdata.pos_y) - 66'(pa_y_reg));
                            e1z_reg <= sat32(66'(pos_rdata.pos_z) - 66'(pa_z_reg));
                        end
                        3'd3:
                        begin
                            e2x_reg <= sat32(66'(pos_rdata.pos_x) - 66'(pa_x_reg));
                            e2y_reg <= sat32(66'(pos_rdata.pos_y) - 66'(pa_y_reg));
                            e2z_reg <= sat32(66'(pos_rdata.pos_z) - 66'(pa_z_reg));
                        end
                        default: pa_x_reg <= pa_x_reg;
                    endcase
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_TRI_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_TRI_MUL:
                begin
                    if (cnt_reg != 3'd0)
                    begin
                        if (cnt_reg[0])
                        begin
                            pe_reg <= prod_reg;
                        end
                        else
                        begin
                            cr_reg[cnt_reg[2:1] - 2'd1] <= pe_reg - prod_reg;
                        end
                    end
                    if (cnt_reg == 3'd6)
                    begin
                        norm_start_reg <= 1'b1;
                        state_reg      <= S_TRI_NORM;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_TRI_NORM:
                begin
                    if (norm_res.done)
                    begin
                        // drop degenerate triangles
                        state_reg <= norm_res.small_len ? S_IDLE : S_ACC_RD;
                    end
                end
                S_ACC_RD:
                begin
                    state_reg <= S_ACC_WR;
                end
                S_ACC_WR:
                begin
                    if (j_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_RD_ADDR:
                begin
                    state_reg <= S_RD_CHK;
                end
                S_RD_CHK:
                begin
                    cr_reg[0] <= 64'(acc_rdata.acc_x);
                    cr_reg[1] <= 64'(acc_rdata.acc_y);
                    cr_reg[2] <= 64'(acc_rdata.acc_z);
                    if (acc_rdata.acc_x == '0 && acc_rdata.acc_y == '0 &&
                        acc_rdata.acc_z == '0)
                    begin
                        up_reg    <= 1'b1;
                        state_reg <= S_RD_OUT;
                    end
                    else
                    begin
                        up_reg         <= 1'b0;
                        norm_start_reg <= 1'b1;
                        state_reg      <= S_RD_NORM;
                    end
                end
                S_RD_NORM:
                begin
                    if (norm_res.done)
                    begin
                        state_reg <= S_RD_OUT;
                    end
                end
                S_RD_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_px_reg    <= pos_rdata.pos_x;
                        out_py_reg    <= pos_rdata.pos_y;
                        out_pz_reg    <= pos_rdata.pos_z;
                        out_tu_reg    <= pos_rdata.tex_u;
                        out_tv_reg    <= pos_rdata.tex_v;
                        out_min_reg   <= run_min_reg;
                        out_nx_reg    <= up_reg ? 16'sd0 : norm_res.nx;
                        out_ny_reg    <= up_reg ? ONE_Q14 : norm_res.ny;
                        out_nz_reg    <= up_reg ? 16'sd0 : norm_res.nz;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = out_px_reg;
    assign pos_y      = out_py_reg;
    assign pos_z      = out_pz_reg;
    assign normal_x   = out_nx_reg;
    assign normal_y   = out_ny_reg;
    assign normal_z   = out_nz_reg;
    assign tex_u      = out_tu_reg;
    assign tex_v      = out_tv_reg;
    assign min_height = out_min_reg;

endmodule

// File: sim/mvna_checker.sv
`timescale 1ns / 100ps
// Checker for the mesh vertex normal accumulator: predicts read results from observed transfers.
// Depends on mvna_pkg for mode and register codes and constants.
module mvna_checker
    import mvna_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [11:0]        vertex_index,
    input  logic [11:0]        grid_col,
    input  logic [11:0]        grid_row,
    input  logic signed [31:0] raw_height,
    input  logic [11:0]        corner_a,
    input  logic [11:0]        corner_b,
    input  logic [11:0]        corner_c,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [16:0]        tex_u,
    input  logic [16:0]        tex_v,
    input  logic signed [31:0] min_height,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fails,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic [16:0]        tu, tv;
        logic signed [31:0] mn;
    } vertex_rec_t;

    vertex_rec_t        reads_due[$];

    logic signed [31:0] org_x, org_y, org_z, stp_x, stp_z, scl_y;
    logic [16:0]        inv_c, inv_r;
    logic signed [31:0] low_mark;

    logic signed [31:0] vx [0:4095];
    logic signed [31:0] vy [0:4095];
    logic signed [31:0] vz [0:4095];
    logic signed [31:0] ax [0:4095];
    logic signed [31:0] ay [0:4095];
    logic signed [31:0] az [0:4095];
    logic [16:0]        tu_mem [0:4095];
    logic [16:0]        tv_mem [0:4095];

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // c must be nonzero
    function automatic void unit_vec(input logic signed [65:0] c0, c1, c2,
                                     output logic signed [15:0] n0, n1, n2);
        logic [65:0]        m0, m1, m2, mx, q0, q1, q2;
        longint unsigned    sq, len;
        int                 s;
        m0 = c0[65] ? -c0 : c0;
        m1 = c1[65] ? -c1 : c1;
        m2 = c2[65] ? -c2 : c2;
        mx = m0 | m1 | m2;
        s = 0;
        while ((mx >> s) >= 66'd1073741824)
            s++;
        m0 = m0 >> s;
        m1 = m1 >> s;
        m2 = m2 >> s;
        sq = 64'(m0 * m0 + m1 * m1 + m2 * m2);
        len = int_root(sq);
        if (len == 0)
            len = 1;
        q0 = (m0 * 66'd16384 + 66'(len / 2)) / 66'(len);
        q1 = (m1 * 66'd16384 + 66'(len / 2)) / 66'(len);
        q2 = (m2 * 66'd16384 + 66'(len / 2)) / 66'(len);
        n0 = c0[65] ? -q0[15:0] : q0[15:0];
        n1 = c1[65] ? -q1[15:0] : q1[15:0];
        n2 = c2[65] ? -q2[15:0] : q2[15:0];
    endfunction

    task automatic store_vertex();
        longint col, row, raw, t;
        col = longint'(grid_col);
        row = longint'(grid_row);
        raw = longint'(raw_height);
        if (raw_height < low_mark)
            low_mark = raw_height;
        vx[vertex_index] = clamp32(66'(longint'(org_x) + col * longint'(stp_x)));
        vz[vertex_index] = clamp32(66'(longint'(org_z) + row * longint'(stp_z)));
        vy[vertex_index] = clamp32(66'(longint'(org_y) +
                                       ((raw * longint'(scl_y) + 32768) >>> 16)));
        t = col * longint'(inv_c);
        tu_mem[vertex_index] = (t > 65536) ? 17'd65536 : t[16:0];
        t = row * longint'(inv_r);
        tv_mem[vertex_index] = (t > 65536) ? 17'd65536 : t[16:0];
        ax[vertex_index] = '0;
        ay[vertex_index] = 32'(ONE_Q14);
        az[vertex_index] = '0;
    endtask

    task automatic add_face();
        logic [11:0]        a, b, c;
        logic signed [65:0] e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
        logic [65:0]        m0, m1, m2;
        logic signed [15:0] n0, n1, n2;
        a = corner_a;
        b = corner_b;
        c = corner_c;
        e1x = 66'(clamp32(66'(vx[b]) - 66'(vx[a])));
        e1y = 66'(clamp32(66'(vy[b]) - 66'(vy[a])));
        e1z = 66'(clamp32(66'(vz[b]) - 66'(vz[a])));
        e2x = 66'(clamp32(66'(vx[c]) - 66'(vx[a])));
        e2y = 66'(clamp32(66'(vy[c]) - 66'(vy[a])));
        e2z = 66'(clamp32(66'(vz[c]) - 66'(vz[a])));
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        m0 = cx[65] ? -cx : cx;
        m1 = cy[65] ? -cy : cy;
        m2 = cz[65] ? -cz : cz;
        // drop faces too small to carry a direction
        if (m0 < 66'h80000000 && m1 < 66'h80000000 && m2 < 66'h80000000)
            if (m0 * m0 + m1 * m1 + m2 * m2 <= 66'd18446744)
                return;
        unit_vec(cx, cy, cz, n0, n1, n2);
        ax[a] = clamp32(66'(ax[a]) + 66'(n0));
        ay[a] = clamp32(66'(ay[a]) + 66'(n1));
        az[a] = clamp32(66'(az[a]) + 66'(n2));
        ax[b] = clamp32(66'(ax[b]) + 66'(n0));
        ay[b] = clamp32(66'(ay[b]) + 66'(n1));
        az[b] = clamp32(66'(az[b]) + 66'(n2));
        ax[c] = clamp32(66'(ax[c]) + 66'(n0));
        ay[c] = clamp32(66'(ay[c]) + 66'(n1));
        az[c] = clamp32(66'(az[c]) + 66'(n2));
    endtask

    task automatic queue_read();
        vertex_rec_t r;
        logic [11:0] i;
        i = vertex_index;
        r.px = vx[i];
        r.py = vy[i];
        r.pz = vz[i];
        r.tu = tu_mem[i];
        r.tv = tv_mem[i];
        r.mn = low_mark;
        if (ax[i] == 0 && ay[i] == 0 && az[i] == 0)
        begin
            r.nx = '0;
            r.ny = ONE_Q14;
            r.nz = '0;
        end
        else
            unit_vec(66'(ax[i]), 66'(ay[i]), 66'(az[i]), r.nx, r.ny, r.nz);
        reads_due.insert(reads_due.size(), r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x    <= 0;
            org_y    <= 0;
            org_z    <= 0;
            stp_x    <= 65536;
            stp_z    <= 65536;
            scl_y    <= 65536;
            inv_c    <= 17'd65536;
            inv_r    <= 17'd65536;
            low_mark <= INT32_MAX;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reads_due.size() == 0)
                begin
                    $error("result transfer with no read outstanding");
                    fails++;
                end
                else
                begin
                    vertex_rec_t w;
                    w = reads_due.pop_front();
                    check_field("pos_x", w.px, pos_x);
                    check_field("pos_y", w.py, pos_y);
                    check_field("pos_z", w.pz, pos_z);
                    check_field("normal_x", w.nx, normal_x);
                    check_field("normal_y", w.ny, normal_y);
                    check_field("normal_z", w.nz, normal_z);
                    check_field("tex_u", w.tu, tex_u);
                    check_field("tex_v", w.tv, tex_v);
                    check_field("min_height", w.mn, min_height);
                end
            end
            if (in_valid && in_ready)
            begin
                case (mode_t'(mode))
                    MODE_START:  low_mark = INT32_MAX;
                    MODE_VERTEX: store_vertex();
                    MODE_TRI:    add_face();
                    MODE_READ:   queue_read();
                endcase
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ORIGIN_X: org_x <= cfg_data;
                    CFG_ORIGIN_Y: org_y <= cfg_data;
                    CFG_ORIGIN_Z: org_z <= cfg_data;
                    CFG_STEP_X:   stp_x <= cfg_data;
                    CFG_STEP_Z:   stp_z <= cfg_data;
                    CFG_SCALE_Y:  scl_y <= cfg_data;
                    CFG_INV_COLS: inv_c <= cfg_data[16:0];
                    CFG_INV_ROWS: inv_r <= cfg_data[16:0];
                endcase
            end
            pending = reads_due.size();
        end
    end

    initial
    begin
        fails   = 0;
        pending = 0;
    end

endmodule

// File: sim/mesh_vertex_normal_accumulator_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives items, register writes and output stalls into the block.
// Depends on mvna_pkg, mesh_vertex_normal_accumulator and mvna_checker.
module mesh_vertex_normal_accumulator_tb;
    import mvna_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [11:0]        vertex_index, grid_col, grid_row;
    logic signed [31:0] raw_height;
    logic [11:0]        corner_a, corner_b, corner_c;
    logic               out_valid, out_ready;
    logic signed [31:0] pos_x, pos_y, pos_z, min_height;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [16:0]        tex_u, tex_v;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fails, pending;
    int                 cycles;
    bit                 calm;
    bit                 loaded [0:4095];
    logic [11:0]        slots [$];
    logic [11:0]        live [$];

    mesh_vertex_normal_accumulator DUT (.*);
    mvna_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls at random unless calm is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic push_item(input mode_t m, input logic [11:0] idx, col, row,
                             input logic [31:0] raw, input logic [11:0] a, b, c);
        mode         <= m;
        vertex_index <= idx;
        grid_col     <= col;
        grid_row     <= row;
        raw_height   <= raw;
        corner_a     <= a;
        corner_b     <= b;
        corner_c     <= c;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        if (m == MODE_VERTEX && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            live.insert(live.size(), idx);
        end
    endtask

    task automatic write_regs(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= v[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // hold until idle; triangles leave no result to wait on, so pad the tail
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8 << 16) - (4 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_grid();
        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, 15));
            1: return 12'hfff;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic random_items(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_item(MODE_START, 12'($urandom), 12'($urandom), 12'($urandom), $urandom,
                          12'($urandom), 12'($urandom), 12'($urandom));
            else if (r < 40)
                push_item(MODE_VERTEX, slots[$urandom_range(0, slots.size() - 1)],
                          pick_grid(), pick_grid(), pick_height(),
                          12'($urandom), 12'($urandom), 12'($urandom));
            else if (r < 75)
                push_item(MODE_TRI, 12'($urandom), 12'($urandom), 12'($urandom), $urandom,
                          live[$urandom_range(0, live.size() - 1)],
                          live[$urandom_range(0, live.size() - 1)],
                          live[$urandom_range(0, live.size() - 1)]);
            else
                push_item(MODE_READ, live[$urandom_range(0, live.size() - 1)],
                          12'($urandom), 12'($urandom), $urandom,
                          12'($urandom), 12'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] regs [8];
        cycles       = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_START;
        vertex_index = '0;
        grid_col     = '0;
        grid_row     = '0;
        raw_height   = '0;
        corner_a     = '0;
        corner_b     = '0;
        corner_c     = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ORIGIN_X;
        cfg_data     = '0;
        slots.insert(slots.size(), 12'h000);
        slots.insert(slots.size(), 12'hfff);
        for (int i = 0; i < 22; i++)
            slots.insert(slots.size(), 12'($urandom));
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: default registers, extreme fields, flat and repeated-corner faces
        push_item(MODE_VERTEX, 12'h000, 12'h000, 12'h000, 32'h7fffffff, '0, '0, '0);
        push_item(MODE_READ, 12'h000, '0, '0, '0, '0, '0, '0);
        push_item(MODE_VERTEX, 12'hfff, 12'hfff, 12'hfff, 32'h80000000, '0, '0, '0);
        push_item(MODE_VERTEX, 12'h001, 12'h001, 12'h000, 32'h00010000, '0, '0, '0);
        push_item(MODE_VERTEX, 12'h002, 12'h000, 12'h001, 32'h00000000, '0, '0, '0);
        push_item(MODE_VERTEX, 12'h003, 12'h001, 12'h001, 32'h00000000, '0, '0, '0);
        push_item(MODE_TRI, '0, '0, '0, '0, 12'h001, 12'h001, 12'h002);
        push_item(MODE_TRI, '0, '0, '0, '0, 12'h002, 12'h003, 12'h001);
        push_item(MODE_TRI, '0, '0, '0, '0, 12'h000, 12'hfff, 12'h001);
        push_item(MODE_TRI, '0, '0, '0, '0, 12'h001, 12'h003, 12'h001);
        push_item(MODE_READ, 12'h001, '0, '0, '0, '0, '0, '0);
        push_item(MODE_READ, 12'hfff, '0, '0, '0, '0, '0, '0);
        push_item(MODE_READ, 12'h003, '0, '0, '0, '0, '0, '0);
        push_item(MODE_START, '0, '0, '0, '0, '0, '0, '0);
        push_item(MODE_READ, 12'h002, '0, '0, '0, '0, '0, '0);
        push_item(MODE_VERTEX, 12'h002, 12'h000, 12'h001, 32'hfffe0000, '0, '0, '0);
        push_item(MODE_READ, 12'h002, '0, '0, '0, '0, '0, '0);
        foreach (slots[i])
            if (!loaded[slots[i]])
                push_item(MODE_VERTEX, slots[i], pick_grid(), pick_grid(), pick_height(),
                          '0, '0, '0);
        random_items(110);
        settle();

        regs = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h0, 32'h10000};
        write_regs(regs);
        random_items(110);
        settle();

        regs = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h10000, 32'h0};
        write_regs(regs);
        random_items(80);
        settle();

        for (int i = 0; i < 6; i++)
            regs[i] = $urandom_range(0, 1 << 20) - (1 << 19);
        regs[6] = $urandom_range(0, 65536);
        regs[7] = $urandom_range(0, 65536);
        write_regs(regs);
        random_items(90);
        calm = 1'b1;
        random_items(60);
        settle();

        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
